>>> src/ifrp_pkg.sv
package ifrp_pkg;

  // Frame layout
  localparam int unsigned HEAD_LEN = 10;  // bytes held before the checksum byte
  localparam int unsigned CNT_W    = 4;

  localparam logic [7:0] SYNC_BYTE  = 8'h55;
  localparam logic [7:0] TYPE_MASK  = 8'h50;
  localparam logic [7:0] TYPE_ACCEL = 8'h51;
  localparam logic [7:0] TYPE_GYRO  = 8'h52;
  localparam logic [7:0] TYPE_ANGLE = 8'h53;
  localparam logic [7:0] TYPE_MAG   = 8'h54;

  // Q15 scale factors (full scale times 2^15 / 2^15)
  localparam logic signed [11:0] GYRO_SCALE  = 12'sd2000;
  localparam logic signed [11:0] ANGLE_SCALE = 12'sd180;

  localparam int unsigned VAL_W = 31;

  typedef enum logic [2:0] {
    KIND_ACCEL  = 3'd0,
    KIND_GYRO   = 3'd1,
    KIND_ANGLE  = 3'd2,
    KIND_MAG    = 3'd3,
    KIND_OTHER  = 3'd4,
    KIND_REJECT = 3'd5
  } kind_t;

  // Classified frame handed from front to back
  typedef struct packed {
    kind_t              kind;
    logic signed [15:0] raw_x;
    logic signed [15:0] raw_y;
    logic signed [15:0] raw_z;
  } frame_item_t;

  // Scaled result
  typedef struct packed {
    kind_t                   kind;
    logic signed [VAL_W-1:0] val_x;
    logic signed [VAL_W-1:0] val_y;
    logic signed [VAL_W-1:0] val_z;
  } frame_result_t;

endpackage

>>> src/ifrp_fifo.sv
module ifrp_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  // Two-entry queue
  logic [WIDTH-1:0] slot_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       count_r, count_nxt;
  logic             push_ok, pop_ok;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign rdata   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push_ok ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop_ok ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push_ok} - {1'b0, pop_ok};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Payload storage, no reset
  always_ff @(posedge clk) begin
    if (push_ok) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

>>> src/ifrp_front.sv
module ifrp_front
  import ifrp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        byte_xfer,   // byte transfer this cycle
  input  logic [7:0]  rx_byte,
  output logic        item_push,
  output frame_item_t item
);

  // Head bytes of the current window; the checksum byte is never stored
  logic [7:0]       win_r [HEAD_LEN];
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [7:0]       sum;
  logic             head_full;
  logic             frame_ok;

  assign head_full = (count_r == CNT_W'(HEAD_LEN));

  // Ten-input checksum over the stored head
  always_comb begin
    sum = 8'd0;
    for (int i = 0; i < HEAD_LEN; i++) begin
      sum = sum + win_r[i];
    end
  end

  assign frame_ok = (win_r[0] == SYNC_BYTE) &&
                    ((win_r[1] & TYPE_MASK) == TYPE_MASK) &&
                    (sum == rx_byte);

  // Classification
  always_comb begin
    item_push  = byte_xfer && head_full;
    item.raw_x = '0;
    item.raw_y = '0;
    item.raw_z = '0;
    if (!frame_ok) begin
      item.kind = KIND_REJECT;
    end else begin
      item.raw_x = {win_r[3], win_r[2]};
      item.raw_y = {win_r[5], win_r[4]};
      item.raw_z = {win_r[7], win_r[6]};
      unique case (win_r[1])
        TYPE_ACCEL: item.kind = KIND_ACCEL;
        TYPE_GYRO:  item.kind = KIND_GYRO;
        TYPE_ANGLE: item.kind = KIND_ANGLE;
        TYPE_MAG:   item.kind = KIND_MAG;
        default:    item.kind = KIND_OTHER;
      endcase
    end
  end

  // Fill count: valid frame restarts, rejected window stays full
  always_comb begin
    count_nxt = count_r;
    if (byte_xfer) begin
      if (!head_full) begin
        count_nxt = count_r + CNT_W'(1);
      end else if (frame_ok) begin
        count_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Window bytes: fill in place, or slide down by one on a rejected window
  always_ff @(posedge clk) begin
    if (byte_xfer) begin
      if (!head_full) begin
        win_r[count_r] <= rx_byte;
      end else if (!frame_ok) begin
        for (int i = 0; i < HEAD_LEN - 1; i++) begin
          win_r[i] <= win_r[i+1];
        end
        win_r[HEAD_LEN-1] <= rx_byte;
      end
    end
  end

endmodule

>>> src/ifrp_back.sv
module ifrp_back
  import ifrp_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          item_valid,
  input  frame_item_t   item,
  output logic          item_pop,
  input  logic          res_pop,
  output logic          res_empty,
  output frame_result_t res
);

  localparam int RES_W = $bits(frame_result_t);

  frame_result_t scaled;
  logic          res_full;
  logic [RES_W-1:0] res_bits;

  // Scale one raw component to Q15
  function automatic logic signed [VAL_W-1:0] scale_comp(
    input kind_t              kind,
    input logic signed [15:0] raw
  );
    logic signed [27:0] prod;
    logic signed [VAL_W-1:0] val;
    prod = '0;
    unique case (kind)
      KIND_ACCEL: val = {{(VAL_W-20){raw[15]}}, raw, 4'b0000};
      KIND_GYRO: begin
        prod = raw * GYRO_SCALE;
        val  = {{(VAL_W-28){prod[27]}}, prod};
      end
      KIND_ANGLE: begin
        prod = raw * ANGLE_SCALE;
        val  = {{(VAL_W-28){prod[27]}}, prod};
      end
      KIND_MAG:   val = {raw, 15'b0};
      default:    val = '0;
    endcase
    return val;
  endfunction

  always_comb begin
    scaled.kind  = item.kind;
    scaled.val_x = scale_comp(item.kind, item.raw_x);
    scaled.val_y = scale_comp(item.kind, item.raw_y);
    scaled.val_z = scale_comp(item.kind, item.raw_z);
  end

  // Move one item per cycle while the result queue has room
  assign item_pop = item_valid && !res_full;

  ifrp_fifo #(
    .WIDTH (RES_W)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (item_pop),
    .wdata (scaled),
    .full  (res_full),
    .pop   (res_pop),
    .rdata (res_bits),
    .empty (res_empty)
  );

  assign res = frame_result_t'(res_bits);

endmodule

>>> src/imu_frame_resync_parser.sv
// A result reaches the output ports once the byte that completes its 11-byte
// window is classified into the middle queue and then scaled into the output
// queue, where it can be popped.
// Throughput: one byte per cycle while full is low; the window check runs in the
// cycle of the byte transfer, and two-entry queues absorb stalls.
// Reset: synchronous active-low rst_n clears the fill count and both queues;
// window bytes are not cleared.
module imu_frame_resync_parser
  import ifrp_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  logic [7:0]              in_rx_byte,
  output logic                    full,
  input  logic                    pop,
  output logic                    empty,
  output logic [2:0]              out_frame_kind,
  output logic signed [VAL_W-1:0] out_value_x,
  output logic signed [VAL_W-1:0] out_value_y,
  output logic signed [VAL_W-1:0] out_value_z
);

  localparam int ITEM_W = $bits(frame_item_t);

  logic             byte_xfer;
  logic             front_push;
  frame_item_t      front_item;
  logic             mid_full, mid_empty, mid_pop;
  logic [ITEM_W-1:0] mid_bits;
  frame_result_t    res;

  assign full      = mid_full;
  assign byte_xfer = push && !mid_full;

  ifrp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_xfer (byte_xfer),
    .rx_byte   (in_rx_byte),
    .item_push (front_push),
    .item      (front_item)
  );

  // Queue between classification and scaling
  ifrp_fifo #(
    .WIDTH (ITEM_W)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (front_push),
    .wdata (front_item),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_bits),
    .empty (mid_empty)
  );

  ifrp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (!mid_empty),
    .item       (frame_item_t'(mid_bits)),
    .item_pop   (mid_pop),
    .res_pop    (pop),
    .res_empty  (empty),
    .res        (res)
  );

  assign out_frame_kind = res.kind;
  assign out_value_x    = res.val_x;
  assign out_value_y    = res.val_y;
  assign out_value_z    = res.val_z;

endmodule

>>> tb/frame_parser_checker.sv
// Watches both channels of the frame parser, keeps its own copy of the
// 11-byte window, and checks every popped result against the oldest
// predicted frame.
module frame_parser_checker
  import ifrp_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  logic                    full,
  input  logic [7:0]              in_rx_byte,
  input  logic                    pop,
  input  logic                    empty,
  input  logic [2:0]              out_frame_kind,
  input  logic signed [VAL_W-1:0] out_value_x,
  input  logic signed [VAL_W-1:0] out_value_y,
  input  logic signed [VAL_W-1:0] out_value_z,
  output int                      mismatches,
  output int                      outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ACCEL_MUL = 16;
  localparam int MAG_MUL   = 32768;

  logic [7:0]    window [0:HEAD_LEN];
  int unsigned   fill;
  frame_result_t expected_frames [$];
  frame_result_t oldest;

  initial begin
    mismatches  = 0;
    outstanding = 0;
    fill        = 0;
  end

  // little-endian signed 16-bit component times its Q15 scale
  function automatic logic signed [VAL_W-1:0] scale_component(input logic [7:0] lo,
                                                              input logic [7:0] hi,
                                                              input int mul);
    logic signed [15:0] raw;
    logic signed [31:0] prod;
    raw  = {hi, lo};
    prod = raw * mul;
    return prod[VAL_W-1:0];
  endfunction

  // add one byte to the window; queue a frame when the window is full
  task automatic absorb_byte(input logic [7:0] b);
    logic [7:0]    sum;
    frame_result_t res;
    int            mul;
    if (fill > HEAD_LEN) fill = HEAD_LEN;
    window[fill] = b;
    fill++;
    if (fill <= HEAD_LEN) return;

    sum = '0;
    for (int i = 0; i < HEAD_LEN; i++) sum += window[i];
    res = '0;
    if (window[0] != SYNC_BYTE || (window[1] & TYPE_MASK) != TYPE_MASK ||
        sum != window[HEAD_LEN]) begin
      // bad window: slide by one byte and try again on the next one
      for (int i = 0; i < HEAD_LEN; i++) window[i] = window[i+1];
      fill     = HEAD_LEN;
      res.kind = KIND_REJECT;
    end else begin
      case (window[1])
        TYPE_ACCEL: begin res.kind = KIND_ACCEL; mul = ACCEL_MUL;   end
        TYPE_GYRO:  begin res.kind = KIND_GYRO;  mul = GYRO_SCALE;  end
        TYPE_ANGLE: begin res.kind = KIND_ANGLE; mul = ANGLE_SCALE; end
        TYPE_MAG:   begin res.kind = KIND_MAG;   mul = MAG_MUL;     end
        default:    begin res.kind = KIND_OTHER; mul = 0;           end
      endcase
      res.val_x = scale_component(window[2], window[3], mul);
      res.val_y = scale_component(window[4], window[5], mul);
      res.val_z = scale_component(window[6], window[7], mul);
      fill      = 0;
    end
    expected_frames.push_back(res);
  endtask

  task automatic check_field(input string name, input logic signed [VAL_W-1:0] want,
                             input logic signed [VAL_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t chk: %s expected %0d got %0d", $time, name, want, got);
    end
  endtask

  // predict on each byte transfer, compare on each result transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      fill = 0;
      expected_frames.delete();
    end else begin
      if (push && !full) absorb_byte(in_rx_byte);
      if (pop && !empty) begin
        if (expected_frames.size() == 0) begin
          mismatches++;
          $display("%0t chk: expected no result, got kind %0d x %0d y %0d z %0d", $time,
                   out_frame_kind, out_value_x, out_value_y, out_value_z);
        end else begin
          oldest = expected_frames.pop_front();
          check_field("frame_kind", {28'b0, oldest.kind}, {28'b0, out_frame_kind});
          check_field("value_x", oldest.val_x, out_value_x);
          check_field("value_y", oldest.val_y, out_value_y);
          check_field("value_z", oldest.val_z, out_value_z);
        end
      end
    end
    outstanding = expected_frames.size();
  end

endmodule

>>> tb/tb.sv
// Byte-stream stimulus for the frame parser: directed frames at the
// component extremes, then random good, broken and cut-short frames mixed
// with noise bytes, with bursty sending and a stalling receiver.
module tb
  import ifrp_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_BYTES = 1600;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 12;

  typedef enum int {FLAW_NONE, FLAW_SUM, FLAW_SYNC, FLAW_TYPE, FLAW_CUT} flaw_t;
  typedef enum int {POP_ALWAYS, POP_COIN, POP_TRICKLE, POP_BURSTY} pop_mode_t;

  logic                    clk;
  logic                    rst_n;
  logic                    push;
  logic [7:0]              in_rx_byte;
  logic                    full;
  logic                    pop = 1'b0;
  logic                    empty;
  logic [2:0]              out_frame_kind;
  logic signed [VAL_W-1:0] out_value_x;
  logic signed [VAL_W-1:0] out_value_y;
  logic signed [VAL_W-1:0] out_value_z;
  int                      mismatches;
  int                      outstanding;

  int        cycles     = 0;
  int        burst_left = 0;
  int        bytes_sent = 0;
  int        mode_left  = 0;
  pop_mode_t pop_mode   = POP_ALWAYS;

  imu_frame_resync_parser dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .in_rx_byte     (in_rx_byte),
    .full           (full),
    .pop            (pop),
    .empty          (empty),
    .out_frame_kind (out_frame_kind),
    .out_value_x    (out_value_x),
    .out_value_y    (out_value_y),
    .out_value_z    (out_value_z)
  );

  frame_parser_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_rx_byte     (in_rx_byte),
    .pop            (pop),
    .empty          (empty),
    .out_frame_kind (out_frame_kind),
    .out_value_x    (out_value_x),
    .out_value_y    (out_value_y),
    .out_value_z    (out_value_z),
    .mismatches     (mismatches),
    .outstanding    (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // receiver: pop pattern switches between randomly chosen modes
  always @(negedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        pop_mode  = pop_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(32, 256);
      end
      mode_left--;
      case (pop_mode)
        POP_ALWAYS:  pop <= 1'b1;
        POP_COIN:    pop <= 1'($urandom_range(0, 1));
        POP_TRICKLE: pop <= ($urandom_range(0, 4) == 0);
        default:     pop <= ((mode_left % 24) < 6);
      endcase
    end
  end

  // one byte transfer, with a random gap between bursts
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 120 : $urandom_range(1, 24);
    end
    push       <= 1'b1;
    in_rx_byte <= b;
    burst_left--;
    bytes_sent++;
    do @(posedge clk); while (full);
    @(negedge clk);
  endtask

  // build an 11-byte frame, optionally damaged or cut short
  task automatic send_frame(input logic [7:0] type_byte, input logic [15:0] x,
                            input logic [15:0] y, input logic [15:0] z, input flaw_t flaw);
    logic [7:0] frame [0:10];
    logic [7:0] sum;
    int         count;
    frame[0] = SYNC_BYTE;
    frame[1] = type_byte;
    frame[2] = x[7:0];
    frame[3] = x[15:8];
    frame[4] = y[7:0];
    frame[5] = y[15:8];
    frame[6] = z[7:0];
    frame[7] = z[15:8];
    frame[8] = 8'($urandom);
    frame[9] = 8'($urandom);
    if (flaw == FLAW_SYNC) begin
      frame[0] = 8'($urandom);
      if (frame[0] == SYNC_BYTE) frame[0][0] = ~frame[0][0];
    end
    // clear one of the two bits that every type byte must carry
    if (flaw == FLAW_TYPE) frame[1] &= ($urandom_range(0, 1) ? 8'hBF : 8'hEF);
    sum = '0;
    for (int i = 0; i < 10; i++) sum += frame[i];
    frame[10] = (flaw == FLAW_SUM) ? sum + 8'($urandom_range(1, 255)) : sum;
    count = (flaw == FLAW_CUT) ? $urandom_range(1, 10) : 11;
    for (int i = 0; i < count; i++) send_byte(frame[i]);
  endtask

  function automatic logic [15:0] rand_component();
    case ($urandom_range(0, 7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'hFFFF;
      3:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] rand_type_byte();
    case ($urandom_range(0, 5))
      0:       return TYPE_ACCEL;
      1:       return TYPE_GYRO;
      2:       return TYPE_ANGLE;
      3:       return TYPE_MAG;
      default: return 8'($urandom) | TYPE_MASK;
    endcase
  endfunction

  // hold the sender until every predicted result has been popped
  task automatic wait_drained();
    push <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
  endtask

  initial begin
    int  pick;
    bit  paused;
    rst_n      = 1'b0;
    push       = 1'b0;
    in_rx_byte = 8'h00;
    paused     = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: leading junk forces a resync, then extremes of every kind
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(TYPE_ACCEL, 16'h7FFF, 16'h8000, 16'h0000, FLAW_NONE);
    send_frame(TYPE_GYRO,  16'h8000, 16'h7FFF, 16'hFFFF, FLAW_NONE);
    send_frame(TYPE_ANGLE, 16'h7FFF, 16'h8000, 16'h0001, FLAW_NONE);
    send_frame(TYPE_MAG,   16'h8000, 16'h7FFF, 16'hFFFF, FLAW_NONE);
    send_frame(8'h50,      16'h1234, 16'h8000, 16'h7FFF, FLAW_NONE);
    send_frame(8'hFF,      16'hFFFF, 16'h0000, 16'h8000, FLAW_NONE);
    send_frame(TYPE_ACCEL, 16'h0001, 16'h0002, 16'h0003, FLAW_SUM);
    send_frame(TYPE_GYRO,  16'h0004, 16'h0005, 16'h0006, FLAW_SYNC);
    send_frame(TYPE_MAG,   16'h0007, 16'h0008, 16'h0009, FLAW_TYPE);
    send_frame(TYPE_ANGLE, 16'hFFFF, 16'h8000, 16'h7FFF, FLAW_NONE);

    // random: mostly good frames, some broken ones and line noise
    bytes_sent = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      if (!paused && bytes_sent > RANDOM_BYTES / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 70)
        send_frame(rand_type_byte(), rand_component(), rand_component(), rand_component(),
                   FLAW_NONE);
      else if (pick < 80)
        send_frame(rand_type_byte(), rand_component(), rand_component(), rand_component(),
                   FLAW_SUM);
      else if (pick < 85)
        send_frame(rand_type_byte(), rand_component(), rand_component(), rand_component(),
                   FLAW_SYNC);
      else if (pick < 90)
        send_frame(rand_type_byte(), rand_component(), rand_component(), rand_component(),
                   FLAW_TYPE);
      else if (pick < 95)
        send_frame(rand_type_byte(), rand_component(), rand_component(), rand_component(),
                   FLAW_CUT);
      else
        repeat ($urandom_range(1, 5)) send_byte(8'($urandom));
    end

    // drain and settle
    push <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

endmodule
